>>> hw/rtl/iprcc_pkg.sv
// iprcc_pkg: shared types and constants for the IPv4 prefix range class counter.
// Holds opcode, sequencer state and class types, field widths and class boundaries.
// No dependencies.
package iprcc_pkg;

    localparam int ADDR_W              = 32;
    localparam int PLEN_W              = 6;
    localparam int COUNT_W             = 11;
    localparam int NUM_CLASSES         = 5;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Last first-octet value of classful classes A to D; class E takes the rest
    localparam logic [7:0] CLASS_A_LAST = 8'd127;
    localparam logic [7:0] CLASS_B_LAST = 8'd191;
    localparam logic [7:0] CLASS_C_LAST = 8'd223;
    localparam logic [7:0] CLASS_D_LAST = 8'd239;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CLS_A = 3'd0,
        CLS_B = 3'd1,
        CLS_C = 3'd2,
        CLS_D = 3'd3,
        CLS_E = 3'd4
    } class_t;

    function automatic class_t class_of(input logic [7:0] octet);
        class_t cls;
        if (octet <= CLASS_A_LAST) begin
            cls = CLS_A;
        end else if (octet <= CLASS_B_LAST) begin
            cls = CLS_B;
        end else if (octet <= CLASS_C_LAST) begin
            cls = CLS_C;
        end else if (octet <= CLASS_D_LAST) begin
            cls = CLS_D;
        end else begin
            cls = CLS_E;
        end
        return cls;
    endfunction

endpackage

>>> hw/rtl/ipv4_prefix_range_class_counter.sv
// ipv4_prefix_range_class_counter: address table with classful prefix range counting.
// Single module: table memory, scan sequencer, shared shift/compare unit, output register.
// Depends on iprcc_pkg.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | opcode, address, prefix_len, low_bound, high_bound
//  out     | out_valid / out_ready| count_class_a .. count_class_e
//
// Load and clear are accepted in the idle state; the block is ready again in the next cycle.
// A query passes through the scan, drain and finish states (an empty table skips scan
// and drain) before its result is registered: the single table read port yields one
// entry per cycle, which feeds one shift-and-range-compare unit.
// rst_n clears the entry count, sequencer and output valid; table contents hold garbage.
// A finished query waits in its last step while an earlier result is not yet taken;
// loads and clears are still accepted while a result waits at the output.
module ipv4_prefix_range_class_counter #(
    parameter int TABLE_DEPTH = iprcc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic [iprcc_pkg::ADDR_W-1:0]       address,
    input  logic [iprcc_pkg::PLEN_W-1:0]       prefix_len,
    input  logic [iprcc_pkg::ADDR_W-1:0]       low_bound,
    input  logic [iprcc_pkg::ADDR_W-1:0]       high_bound,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [iprcc_pkg::COUNT_W-1:0]      count_class_a,
    output logic [iprcc_pkg::COUNT_W-1:0]      count_class_b,
    output logic [iprcc_pkg::COUNT_W-1:0]      count_class_c,
    output logic [iprcc_pkg::COUNT_W-1:0]      count_class_d,
    output logic [iprcc_pkg::COUNT_W-1:0]      count_class_e
);

    // Table index width and entry count width (count must hold TABLE_DEPTH itself)
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W  = iprcc_pkg::ADDR_W;
    localparam int PLEN_W  = iprcc_pkg::PLEN_W;
    localparam int COUNT_W = iprcc_pkg::COUNT_W;
    localparam int NCLS    = iprcc_pkg::NUM_CLASSES;

    // Address table: written on load, read one entry per cycle during a scan
    logic [ADDR_W-1:0] table_mem [TABLE_DEPTH];

    iprcc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]      entry_count_reg, entry_count_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]  rdata_reg;
    logic [PLEN_W-1:0]  shift_reg, shift_next;
    logic [ADDR_W-1:0]  low_reg, low_next;
    logic [ADDR_W-1:0]  high_reg, high_next;
    logic [COUNT_W-1:0] cnt_reg [NCLS];
    logic [COUNT_W-1:0] cnt_next [NCLS];
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_cnt_reg [NCLS];
    logic [COUNT_W-1:0] out_cnt_next [NCLS];

    logic               in_accept;
    logic               load_wr;
    logic               table_full;
    logic [PLEN_W-1:0]  plen_sat;
    logic [ADDR_W-1:0]  prefix;
    logic               hit;
    iprcc_pkg::class_t  hit_cls;
    logic               last_read;

    assign in_ready   = (state_reg == iprcc_pkg::ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign table_full = (entry_count_reg >= CW'(TABLE_DEPTH));
    assign load_wr    = in_accept && (opcode == iprcc_pkg::OP_LOAD) && !table_full;

    // Saturate the prefix length to the full address
    assign plen_sat = (prefix_len > iprcc_pkg::PLEN_MAX) ? iprcc_pkg::PLEN_MAX : prefix_len;

    // Shared unit: shift the entry down to its prefix and range-check it.
    // A shift of the full width yields zero, covering a prefix length of zero.
    assign prefix  = rdata_reg >> shift_reg;
    assign hit     = rd_valid_reg && (prefix >= low_reg) && (prefix <= high_reg);
    assign hit_cls = iprcc_pkg::class_of(rdata_reg[ADDR_W-1 -: 8]);

    assign last_read = ((CW'(rd_idx_reg) + CW'(1)) == entry_count_reg);

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            table_mem[entry_count_reg[AW-1:0]] <= address;
        end
        rdata_reg <= table_mem[rd_idx_reg];
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        rd_idx_next      = rd_idx_reg;
        rd_valid_next    = 1'b0;
        shift_next       = shift_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        cnt_next         = cnt_reg;
        out_cnt_next     = out_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        // Accumulate the entry read in the previous cycle
        if (hit)
        begin
            cnt_next[hit_cls] = cnt_reg[hit_cls] + COUNT_W'(1);
        end

        unique case (state_reg)
            iprcc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (iprcc_pkg::op_t'(opcode))
                        iprcc_pkg::OP_LOAD:
                        begin
                            // drop the address when the table is full
                            if (!table_full)
                            begin
                                entry_count_next = entry_count_reg + CW'(1);
                            end
                        end
                        iprcc_pkg::OP_QUERY:
                        begin
                            shift_next  = PLEN_W'(ADDR_W) - plen_sat;
                            low_next    = low_bound;
                            high_next   = high_bound;
                            rd_idx_next = '0;
                            for (int c = 0; c < NCLS; c++)
                            begin
                                cnt_next[c] = '0;
                            end
                            state_next = (entry_count_reg == '0) ? iprcc_pkg::ST_FINISH
                                                                 : iprcc_pkg::ST_SCAN;
                        end
                        iprcc_pkg::OP_CLEAR:
                        begin
                            entry_count_next = '0;
                        end
                        default:
                        begin
                            // reserved opcode: ignore
                        end
                    endcase
                end
            end
            iprcc_pkg::ST_SCAN:
            begin
                rd_valid_next = 1'b1;
                if (last_read)
                begin
                    state_next = iprcc_pkg::ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end
            iprcc_pkg::ST_DRAIN:
            begin
                // last entry is evaluated this cycle
                state_next = iprcc_pkg::ST_FINISH;
            end
            iprcc_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_cnt_next   = cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = iprcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iprcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= iprcc_pkg::ST_IDLE;
            entry_count_reg <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        shift_reg   <= shift_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        cnt_reg     <= cnt_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid     = out_valid_reg;
    assign count_class_a = out_cnt_reg[iprcc_pkg::CLS_A];
    assign count_class_b = out_cnt_reg[iprcc_pkg::CLS_B];
    assign count_class_c = out_cnt_reg[iprcc_pkg::CLS_C];
    assign count_class_d = out_cnt_reg[iprcc_pkg::CLS_D];
    assign count_class_e = out_cnt_reg[iprcc_pkg::CLS_E];

endmodule
